// ----- design/kct_pkg.sv -----
// kct_pkg: shared types, register indexes and fixed-point helpers for the
// constant-velocity tracker. Used by kalman_cv_tracker_4state; no dependencies.
package kct_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MM_MUL,
    ST_MM_ACC,
    ST_PIV_START,
    ST_PIV_SRCH,
    ST_PIV_CHK,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_DIV_WB,
    ST_ELIM_F,
    ST_ELIM_MUL,
    ST_ELIM_ACC,
    ST_FINISH
  } kct_state_e;

  // matrix product passes
  typedef enum logic [2:0] {
    OP_XM,   // xm = A * xhat
    OP_AP,   // t = A * P
    OP_PAT,  // pm = t * A^T + Q, s = pm + R
    OP_KG,   // k = pm * inv(s)
    OP_UPD,  // xhat = xm + k * innov
    OP_KP    // P = pm - k * pm
  } kct_op_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_SAMPLE_PERIOD = 3'd0,
    CFG_Q_POSITION    = 3'd1,
    CFG_Q_VELOCITY    = 3'd2,
    CFG_R_POS_X       = 3'd3,
    CFG_R_POS_Y       = 3'd4,
    CFG_R_VEL_X       = 3'd5,
    CFG_R_VEL_Y       = 3'd6,
    CFG_UNUSED        = 3'd7
  } kct_cfg_e;

  localparam logic signed [31:0] Q_ONE = 32'sd65536;

  // saturate to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return signed'(v[31:0]);
    end
  endfunction

  // magnitude as unsigned, the most negative value maps to 2^31
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // element of the transition matrix A
  function automatic logic signed [31:0] a_elem(input logic [1:0] r, input logic [1:0] c,
                                                input logic [15:0] t);
    if (r == c) begin
      return Q_ONE;
    end else if ((r == 2'd0 && c == 2'd2) || (r == 2'd1 && c == 2'd3)) begin
      return signed'({16'd0, t});
    end else begin
      return 32'sd0;
    end
  endfunction

endpackage

// ----- design/kalman_cv_tracker_4state.sv -----
// kalman_cv_tracker_4state: four-state constant-velocity Kalman filter, Q15.16.
// The six matrix passes run on one shared multiplier, and the Gauss-Jordan inverse
// uses a bit-serial pivot divider for its 32 divisions. One item at a time;
// the next is taken while a finished result waits. Reset (async, active low) clears
// the estimate and covariance and loads the register defaults. Uses kct_pkg.
module kalman_cv_tracker_4state (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write port
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  // measurement item in
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // meas_x, meas_y, meas_vx, meas_vy
  // estimate item out
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // est_x, est_y, est_vx, est_vy
  output logic         m_axis_tuser    // singular_flag
);

  kct_pkg::kct_state_e state_q, state_d;
  kct_pkg::kct_op_e    op_q;

  // configuration registers
  logic [15:0] sample_period_q;
  logic [31:0] q_position_q, q_velocity_q;
  logic [31:0] r_pos_x_q, r_pos_y_q, r_vel_x_q, r_vel_y_q;

  // state and working matrices, index {row, col}
  logic signed [31:0] xhat_q [4];
  logic signed [31:0] xm_q [4];
  logic signed [31:0] z_q [4];
  logic signed [31:0] innov_q [4];
  logic signed [31:0] p_q [16];
  logic signed [31:0] t_q [16];
  logic signed [31:0] pm_q [16];
  logic signed [31:0] m_q [16];
  logic signed [31:0] inv_q [16];
  logic signed [31:0] k_q [16];

  // sequencing counters
  logic [1:0] i_q, j_q, kk_q;
  logic [1:0] c_q, pr_q, r_q, er_q;
  logic [2:0] jd_q;
  logic [5:0] cnt_q;
  logic       sing_q;

  // shared multiplier and accumulator
  logic signed [31:0] op_a, op_b;
  logic signed [63:0] mul_full;
  logic signed [47:0] mul_rnd;
  logic signed [47:0] prod_q;
  logic signed [49:0] acc_q, acc_sum;
  logic signed [31:0] wb_sat;

  // pivot and divider
  logic [31:0]        pmag_q;
  logic signed [31:0] piv_q;
  logic signed [31:0] f_q;
  logic [47:0]        dvd_q;
  logic [31:0]        rem_q;
  logic [31:0]        dmag_q;
  logic               neg_q;
  logic [32:0]        rem_sh;
  logic               rem_ge;
  logic signed [31:0] div_res;
  logic signed [31:0] div_opnd;

  // output register
  logic               m_valid_q;
  logic [127:0]       m_data_q;
  logic               m_user_q;

  // pass geometry
  logic       one_col;
  logic       elem_done, mm_done;
  logic [2:0] er_inc, er_nxt;
  logic       er_last;

  assign one_col   = (op_q == kct_pkg::OP_XM) || (op_q == kct_pkg::OP_UPD);
  assign elem_done = (kk_q == 2'd3);
  assign mm_done   = elem_done && (i_q == 2'd3) && (one_col || (j_q == 2'd3));

  // next elimination row, skipping the pivot row
  assign er_inc  = {1'b0, er_q} + 3'd1;
  assign er_nxt  = (!er_inc[2] && er_inc[1:0] == c_q) ? er_inc + 3'd1 : er_inc;
  assign er_last = er_nxt[2];

  // operand selection for the shared multiplier
  always_comb begin
    op_a = 32'sd0;
    op_b = 32'sd0;
    if (state_q == kct_pkg::ST_ELIM_MUL) begin
      op_a = f_q;
      op_b = jd_q[2] ? inv_q[{c_q, jd_q[1:0]}] : m_q[{c_q, jd_q[1:0]}];
    end else begin
      unique case (op_q)
        kct_pkg::OP_XM: begin
          op_a = kct_pkg::a_elem(i_q, kk_q, sample_period_q);
          op_b = xhat_q[kk_q];
        end
        kct_pkg::OP_AP: begin
          op_a = kct_pkg::a_elem(i_q, kk_q, sample_period_q);
          op_b = p_q[{kk_q, j_q}];
        end
        kct_pkg::OP_PAT: begin
          op_a = t_q[{i_q, kk_q}];
          op_b = kct_pkg::a_elem(j_q, kk_q, sample_period_q);
        end
        kct_pkg::OP_KG: begin
          op_a = pm_q[{i_q, kk_q}];
          op_b = inv_q[{kk_q, j_q}];
        end
        kct_pkg::OP_UPD: begin
          op_a = k_q[{i_q, kk_q}];
          op_b = innov_q[kk_q];
        end
        kct_pkg::OP_KP: begin
          op_a = k_q[{i_q, kk_q}];
          op_b = pm_q[{kk_q, j_q}];
        end
        default: begin
          op_a = 32'sd0;
          op_b = 32'sd0;
        end
      endcase
    end
  end

  // rounded Q15.16 product, round half up
  assign mul_full = op_a * op_b;
  assign mul_rnd  = 48'((mul_full + 64'sd32768) >>> 16);
  assign acc_sum  = acc_q + 50'(prod_q);
  assign wb_sat   = kct_pkg::sat32(64'(acc_sum));

  // write-back values for the covariance prediction pass
  logic [31:0]        qd, rd;
  logic signed [31:0] pm_val, s_val;
  always_comb begin
    qd = i_q[1] ? q_velocity_q : q_position_q;
    unique case (i_q)
      2'd0:    rd = r_pos_x_q;
      2'd1:    rd = r_pos_y_q;
      2'd2:    rd = r_vel_x_q;
      default: rd = r_vel_y_q;
    endcase
    pm_val = (i_q == j_q) ? kct_pkg::sat32(64'(wb_sat) + {32'd0, qd}) : wb_sat;
    s_val  = (i_q == j_q) ? kct_pkg::sat32(64'(pm_val) + {32'd0, rd}) : pm_val;
  end

  // restoring divider step and result saturation
  assign rem_sh   = {rem_q, dvd_q[47]};
  assign rem_ge   = rem_sh >= {1'b0, dmag_q};
  assign div_opnd = jd_q[2] ? inv_q[{c_q, jd_q[1:0]}] : m_q[{c_q, jd_q[1:0]}];
  always_comb begin
    if (neg_q) begin
      div_res = (dvd_q > 48'h0000_8000_0000) ? 32'sh80000000 : signed'(32'(-dvd_q));
    end else begin
      div_res = (dvd_q > 48'h0000_7fff_ffff) ? 32'sh7fffffff : signed'(dvd_q[31:0]);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kct_pkg::ST_IDLE:      if (s_axis_tvalid) state_d = kct_pkg::ST_MM_MUL;
      kct_pkg::ST_MM_MUL:    state_d = kct_pkg::ST_MM_ACC;
      kct_pkg::ST_MM_ACC: begin
        if (!mm_done) begin
          state_d = kct_pkg::ST_MM_MUL;
        end else if (op_q == kct_pkg::OP_PAT) begin
          state_d = kct_pkg::ST_PIV_START;
        end else if (op_q == kct_pkg::OP_KP) begin
          state_d = kct_pkg::ST_FINISH;
        end else begin
          state_d = kct_pkg::ST_MM_MUL;
        end
      end
      kct_pkg::ST_PIV_START: state_d = (c_q == 2'd3) ? kct_pkg::ST_PIV_CHK
                                                     : kct_pkg::ST_PIV_SRCH;
      kct_pkg::ST_PIV_SRCH:  if (r_q == 2'd3) state_d = kct_pkg::ST_PIV_CHK;
      kct_pkg::ST_PIV_CHK:   state_d = (pmag_q == 32'd0) ? kct_pkg::ST_MM_MUL
                                                         : kct_pkg::ST_DIV_LOAD;
      kct_pkg::ST_DIV_LOAD:  state_d = kct_pkg::ST_DIV_RUN;
      kct_pkg::ST_DIV_RUN:   if (cnt_q == 6'd47) state_d = kct_pkg::ST_DIV_WB;
      kct_pkg::ST_DIV_WB:    state_d = (jd_q == 3'd7) ? kct_pkg::ST_ELIM_F
                                                      : kct_pkg::ST_DIV_LOAD;
      kct_pkg::ST_ELIM_F:    state_d = kct_pkg::ST_ELIM_MUL;
      kct_pkg::ST_ELIM_MUL:  state_d = kct_pkg::ST_ELIM_ACC;
      kct_pkg::ST_ELIM_ACC: begin
        if (jd_q != 3'd7) begin
          state_d = kct_pkg::ST_ELIM_MUL;
        end else if (!er_last) begin
          state_d = kct_pkg::ST_ELIM_F;
        end else if (c_q == 2'd3) begin
          state_d = kct_pkg::ST_MM_MUL;
        end else begin
          state_d = kct_pkg::ST_PIV_START;
        end
      end
      kct_pkg::ST_FINISH:    if (!m_valid_q || m_axis_tready) state_d = kct_pkg::ST_IDLE;
      default:               state_d = kct_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    s_axis_tready = (state_q == kct_pkg::ST_IDLE);
    m_axis_tvalid = m_valid_q;
    m_axis_tdata  = m_data_q;
    m_axis_tuser  = m_user_q;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kct_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == kct_pkg::ST_FINISH && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_period_q <= 16'd655;
      q_position_q    <= 32'd65536;
      q_velocity_q    <= 32'd65536;
      r_pos_x_q       <= 32'd32768;
      r_pos_y_q       <= 32'd13107;
      r_vel_x_q       <= 32'd3276800;
      r_vel_y_q       <= 32'd3276800;
    end else if (cfg_we_i) begin
      unique case (kct_pkg::kct_cfg_e'(cfg_idx_i))
        kct_pkg::CFG_SAMPLE_PERIOD: sample_period_q <= cfg_data_i[15:0];
        kct_pkg::CFG_Q_POSITION:    q_position_q    <= cfg_data_i;
        kct_pkg::CFG_Q_VELOCITY:    q_velocity_q    <= cfg_data_i;
        kct_pkg::CFG_R_POS_X:       r_pos_x_q       <= cfg_data_i;
        kct_pkg::CFG_R_POS_Y:       r_pos_y_q       <= cfg_data_i;
        kct_pkg::CFG_R_VEL_X:       r_vel_x_q       <= cfg_data_i;
        kct_pkg::CFG_R_VEL_Y:       r_vel_y_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // filter state: estimate and covariance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < 4; n++) xhat_q[n] <= 32'sd0;
      for (int n = 0; n < 16; n++) p_q[n] <= 32'sd0;
    end else if (state_q == kct_pkg::ST_MM_ACC && elem_done) begin
      if (op_q == kct_pkg::OP_UPD) begin
        xhat_q[i_q] <= kct_pkg::sat32(64'(xm_q[i_q]) + 64'(wb_sat));
      end
      if (op_q == kct_pkg::OP_KP) begin
        p_q[{i_q, j_q}] <= kct_pkg::sat32(64'(pm_q[{i_q, j_q}]) - 64'(wb_sat));
      end
    end
  end

  // sequencer datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      // take the measurement, start with xm = A * xhat
      kct_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          for (int n = 0; n < 4; n++) z_q[n] <= signed'(s_axis_tdata[32*n +: 32]);
          for (int n = 0; n < 16; n++) inv_q[n] <= (n % 5 == 0) ? kct_pkg::Q_ONE : 32'sd0;
          op_q   <= kct_pkg::OP_XM;
          i_q    <= 2'd0;
          j_q    <= 2'd0;
          kk_q   <= 2'd0;
          acc_q  <= 50'sd0;
          sing_q <= 1'b0;
          c_q    <= 2'd0;
        end
      end
      kct_pkg::ST_MM_MUL: prod_q <= mul_rnd;
      // accumulate, write back a finished element
      kct_pkg::ST_MM_ACC: begin
        kk_q <= kk_q + 2'd1;
        if (!elem_done) begin
          acc_q <= acc_sum;
        end else begin
          acc_q <= 50'sd0;
          if (one_col || j_q == 2'd3) begin
            j_q <= 2'd0;
            i_q <= i_q + 2'd1;
          end else begin
            j_q <= j_q + 2'd1;
          end
          unique case (op_q)
            kct_pkg::OP_XM: begin
              xm_q[i_q]    <= wb_sat;
              innov_q[i_q] <= kct_pkg::sat32(64'(z_q[i_q]) - 64'(wb_sat));
            end
            kct_pkg::OP_AP:  t_q[{i_q, j_q}] <= wb_sat;
            kct_pkg::OP_PAT: begin
              pm_q[{i_q, j_q}] <= pm_val;
              m_q[{i_q, j_q}]  <= s_val;
            end
            kct_pkg::OP_KG:  k_q[{i_q, j_q}] <= wb_sat;
            default: ;
          endcase
          if (mm_done) begin
            unique case (op_q)
              kct_pkg::OP_XM:  op_q <= kct_pkg::OP_AP;
              kct_pkg::OP_AP:  op_q <= kct_pkg::OP_PAT;
              kct_pkg::OP_KG:  op_q <= kct_pkg::OP_UPD;
              kct_pkg::OP_UPD: op_q <= kct_pkg::OP_KP;
              default: ;
            endcase
          end
        end
      end
      // pivot search over column c
      kct_pkg::ST_PIV_START: begin
        pmag_q <= kct_pkg::mag32(m_q[{c_q, c_q}]);
        pr_q   <= c_q;
        r_q    <= c_q + 2'd1;
      end
      kct_pkg::ST_PIV_SRCH: begin
        if (kct_pkg::mag32(m_q[{r_q, c_q}]) > pmag_q) begin
          pmag_q <= kct_pkg::mag32(m_q[{r_q, c_q}]);
          pr_q   <= r_q;
        end
        r_q <= r_q + 2'd1;
      end
      // zero pivot gives K = 0, else swap rows and start dividing
      kct_pkg::ST_PIV_CHK: begin
        if (pmag_q == 32'd0) begin
          for (int n = 0; n < 16; n++) k_q[n] <= 32'sd0;
          sing_q <= 1'b1;
          op_q   <= kct_pkg::OP_UPD;
          i_q    <= 2'd0;
          j_q    <= 2'd0;
          kk_q   <= 2'd0;
          acc_q  <= 50'sd0;
        end else begin
          for (int n = 0; n < 4; n++) begin
            m_q[{c_q, 2'(n)}]   <= m_q[{pr_q, 2'(n)}];
            m_q[{pr_q, 2'(n)}]  <= m_q[{c_q, 2'(n)}];
            inv_q[{c_q, 2'(n)}]  <= inv_q[{pr_q, 2'(n)}];
            inv_q[{pr_q, 2'(n)}] <= inv_q[{c_q, 2'(n)}];
          end
          piv_q <= m_q[{pr_q, c_q}];
          jd_q  <= 3'd0;
        end
      end
      kct_pkg::ST_DIV_LOAD: begin
        dvd_q  <= {kct_pkg::mag32(div_opnd), 16'd0};
        rem_q  <= 32'd0;
        dmag_q <= kct_pkg::mag32(piv_q);
        neg_q  <= div_opnd[31] ^ piv_q[31];
        cnt_q  <= 6'd0;
      end
      // one quotient bit per cycle
      kct_pkg::ST_DIV_RUN: begin
        rem_q <= rem_ge ? 32'(rem_sh - {1'b0, dmag_q}) : rem_sh[31:0];
        dvd_q <= {dvd_q[46:0], rem_ge};
        cnt_q <= cnt_q + 6'd1;
      end
      kct_pkg::ST_DIV_WB: begin
        if (jd_q[2]) inv_q[{c_q, jd_q[1:0]}] <= div_res;
        else         m_q[{c_q, jd_q[1:0]}]   <= div_res;
        jd_q <= jd_q + 3'd1;
        if (jd_q == 3'd7) er_q <= (c_q == 2'd0) ? 2'd1 : 2'd0;
      end
      // elimination of column c from row er
      kct_pkg::ST_ELIM_F: begin
        f_q  <= m_q[{er_q, c_q}];
        jd_q <= 3'd0;
      end
      kct_pkg::ST_ELIM_MUL: prod_q <= mul_rnd;
      kct_pkg::ST_ELIM_ACC: begin
        if (jd_q[2]) begin
          inv_q[{er_q, jd_q[1:0]}] <=
            kct_pkg::sat32(64'(inv_q[{er_q, jd_q[1:0]}]) - 64'(prod_q));
        end else begin
          m_q[{er_q, jd_q[1:0]}] <=
            kct_pkg::sat32(64'(m_q[{er_q, jd_q[1:0]}]) - 64'(prod_q));
        end
        jd_q <= jd_q + 3'd1;
        if (jd_q == 3'd7) begin
          er_q <= er_nxt[1:0];
          if (er_last) begin
            c_q <= c_q + 2'd1;
            if (c_q == 2'd3) begin
              op_q <= kct_pkg::OP_KG;
              i_q  <= 2'd0;
              j_q  <= 2'd0;
              kk_q <= 2'd0;
              acc_q <= 50'sd0;
            end
          end
        end
      end
      // load the output register
      kct_pkg::ST_FINISH: begin
        if (!m_valid_q || m_axis_tready) begin
          m_data_q <= {xhat_q[3], xhat_q[2], xhat_q[1], xhat_q[0]};
          m_user_q <= sing_q;
        end
      end
      default: ;
    endcase
  end

endmodule
